@@ design/pct4_pkg.sv @@
`timescale 1ns / 1ps

package pct4_pkg;

    localparam int NUM_CH     = 4;
    localparam int CNT_W      = 16;
    localparam int PRESC_W    = 9;
    localparam int SHIFT_W    = 4;
    localparam int MAX_SHIFT  = 9;
    localparam int CFG_ADDR_W = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [SHIFT_W-1:0]    PRESCALE_RESET = SHIFT_W'(1);

    localparam logic [CFG_ADDR_W-1:0] REG_PRESCALE  = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_MODE      = CFG_ADDR_W'(1);
    localparam logic [CFG_ADDR_W-1:0] REG_INTERVAL0 = CFG_ADDR_W'(2);
    localparam logic [CFG_ADDR_W-1:0] REG_ENABLE    = CFG_ADDR_W'(6);

    typedef struct packed {
        logic base_tick;
        logic count_pulse;
    } t_in_item;

    typedef struct packed {
        logic [CNT_W-1:0]  count_value;
        logic [NUM_CH-1:0] fired_mask;
    } t_out_item;

    typedef struct packed {
        logic [SHIFT_W-1:0]           prescale_shift;
        logic                         count_mode;
        logic [NUM_CH-1:0][CNT_W-1:0] interval;
        logic [NUM_CH-1:0]            channel_enable;
    } t_cfg;

endpackage

@@ design/pct4_cfg.sv @@
`timescale 1ns / 1ps

module pct4_cfg import pct4_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic [CFG_ADDR_W-1:0] i_wr_index,
    input  logic [CFG_DATA_W-1:0] i_wr_data,
    output t_cfg                  o_cfg,
    output logic [NUM_CH-1:0]     o_load,
    output logic [CNT_W-1:0]      o_load_value
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg  = r_cfg;
        o_load = '0;
        if (i_wr_en) begin
            if (i_wr_index == REG_PRESCALE) begin
                n_cfg.prescale_shift = i_wr_data[SHIFT_W-1:0];
            end
            if (i_wr_index == REG_MODE) begin
                n_cfg.count_mode = i_wr_data[0];
            end
            for (int ch = 0; ch < NUM_CH; ch++) begin
                if (i_wr_index == REG_INTERVAL0 + CFG_ADDR_W'(ch)) begin
                    n_cfg.interval[ch] = i_wr_data[CNT_W-1:0];
                    o_load[ch]         = 1'b1;
                end
            end
            if (i_wr_index == REG_ENABLE) begin
                n_cfg.channel_enable = i_wr_data[NUM_CH-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prescale_shift <= PRESCALE_RESET;
            r_cfg.count_mode     <= 1'b0;
            r_cfg.interval       <= '0;
            r_cfg.channel_enable <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg        = r_cfg;
    assign o_load_value = i_wr_data[CNT_W-1:0];

endmodule

@@ design/pct4_core.sv @@
`timescale 1ns / 1ps

module pct4_core import pct4_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic [NUM_CH-1:0] i_load,
    input  logic [CNT_W-1:0]  i_load_value,
    input  logic              i_step,
    input  t_in_item          i_item,
    output t_out_item         o_result,
    output logic [CNT_W-1:0]  o_count
);

    logic [PRESC_W-1:0]           r_presc;
    logic [PRESC_W-1:0]           n_presc;
    logic [CNT_W-1:0]             r_count;
    logic [CNT_W-1:0]             n_count;
    logic [NUM_CH-1:0][CNT_W-1:0] r_cmp;
    logic [NUM_CH-1:0][CNT_W-1:0] n_cmp;

    logic [SHIFT_W-1:0] w_shift;
    logic [PRESC_W:0]   w_presc_inc;
    logic [PRESC_W:0]   w_limit;
    logic [CNT_W-1:0]   w_count_inc;
    logic               w_advance;
    logic [NUM_CH-1:0]  w_fired;

    always_comb begin
        w_shift     = (i_cfg.prescale_shift > SHIFT_W'(MAX_SHIFT)) ?
                      SHIFT_W'(MAX_SHIFT) : i_cfg.prescale_shift;
        w_presc_inc = {1'b0, r_presc} + (PRESC_W+1)'(1);
        w_limit     = (PRESC_W+1)'(1) << w_shift;
        w_count_inc = r_count + CNT_W'(1);
        n_presc     = r_presc;
        w_advance   = 1'b0;
        if (i_step) begin
            if (!i_cfg.count_mode) begin
                if (i_item.base_tick) begin
                    if (w_presc_inc >= w_limit) begin
                        n_presc   = '0;
                        w_advance = 1'b1;
                    end else begin
                        n_presc = w_presc_inc[PRESC_W-1:0];
                    end
                end
            end else begin
                w_advance = i_item.count_pulse;
            end
        end
        n_count = w_advance ? w_count_inc : r_count;
    end

    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            w_fired[ch] = w_advance && i_cfg.channel_enable[ch] && (r_cmp[ch] == w_count_inc);
            if (i_load[ch]) begin
                n_cmp[ch] = i_load_value;
            end else if (w_fired[ch]) begin
                n_cmp[ch] = r_cmp[ch] + i_cfg.interval[ch];
            end else begin
                n_cmp[ch] = r_cmp[ch];
            end
        end
    end

    // interval writes reload the compare register at the same edge as the config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_presc <= '0;
            r_count <= '0;
            r_cmp   <= '0;
        end else begin
            r_presc <= n_presc;
            r_count <= n_count;
            r_cmp   <= n_cmp;
        end
    end

    assign o_result.count_value = n_count;
    assign o_result.fired_mask  = w_fired;
    assign o_count              = r_count;

endmodule

@@ design/periodic_compare_timer_4ch.sv @@
`timescale 1ns / 1ps

// periodic_compare_timer_4ch: 16-bit up counter with four periodic compare channels
// input channel (i_in_valid / o_in_ready / i_in_data): one request per base tick
//   or count pulse, carrying base_tick and count_pulse
// output channel (o_out_valid / i_out_ready / o_out_data): exactly one result per
//   request, the count after it and the mask of channels that fired
// config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data): always
//   ready; index 0 prescale shift, 1 count mode, 2 to 5 channel intervals,
//   6 channel enables; an interval write also reloads that channel's compare value
// path: a request accepted is loaded into the input register, its result is computed
//   from there and registered in the output register, which drives o_out_valid
// throughput: one request per cycle while results are taken, set by the single pass
//   from input register through count and compare logic into the output register
// stall: while i_out_ready is low the result holds, one more request may wait in
//   the input register, then o_in_ready drops
// reset: synchronous active low; count, prescaler, compare values and intervals
//   clear, prescale shift returns to 1, both pipeline registers empty
module periodic_compare_timer_4ch import pct4_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_ADDR_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    t_cfg              w_cfg;
    logic [NUM_CH-1:0] w_load;
    logic [CNT_W-1:0]  w_load_value;
    logic              w_out_adv;
    logic              w_step;
    t_out_item         w_result;
    logic [CNT_W-1:0]  w_count;

    assign o_cfg_ready = 1'b1;
    assign w_out_adv   = !r_out_valid || i_out_ready;
    assign w_step      = r_in_valid && w_out_adv;
    assign o_in_ready  = !r_in_valid || w_out_adv;

    pct4_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr_en      (i_cfg_valid),
        .i_wr_index   (i_cfg_index),
        .i_wr_data    (i_cfg_data),
        .o_cfg        (w_cfg),
        .o_load       (w_load),
        .o_load_value (w_load_value)
    );

    pct4_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_load       (w_load),
        .i_load_value (w_load_value),
        .i_step       (w_step),
        .i_item       (r_in_item),
        .o_result     (w_result),
        .o_count      (w_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_out_adv) begin
                r_out_valid <= w_step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_data;
        end
        if (w_step) begin
            r_out_item <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

`ifndef NO_ASSERTIONS
    a_fired_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.fired_mask & ~w_cfg.channel_enable) == '0))
        else $error("fired channel not enabled");

    a_count_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.count_value == w_count))
        else $error("shown count differs from count register");

    a_step_when_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> o_out_valid)
        else $error("stepped request produced no result");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !r_in_valid))
        else $error("pipeline not empty after reset");
`endif

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import pct4_pkg::*;

    localparam int LIMIT_NS    = 20_000_000;
    localparam int MAX_REPORTS = 20;
    localparam int SETTLE_CYC  = 4;
    localparam int PLAN_ROWS   = 25;

    localparam logic [CFG_ADDR_W-1:0] REG_INTERVAL1 = REG_INTERVAL0 + CFG_ADDR_W'(1);
    localparam logic [CFG_ADDR_W-1:0] REG_INTERVAL2 = REG_INTERVAL0 + CFG_ADDR_W'(2);
    localparam logic [CFG_ADDR_W-1:0] REG_INTERVAL3 = REG_INTERVAL0 + CFG_ADDR_W'(3);
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE     = REG_ENABLE + CFG_ADDR_W'(1);
    localparam logic [CFG_ADDR_W-1:0] REG_LAST      = '1;

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_ADDR_W-1:0] idx;
        logic [CFG_DATA_W-1:0] data;
        t_in_item              req;
        logic                  typed;
        t_out_item             want;
    } t_plan_row;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_in_item              i_in_data   = '0;
    logic                  i_out_ready = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    t_out_item             o_out_data;
    logic                  o_cfg_ready;

    // timer shadow state
    logic [SHIFT_W-1:0] tmr_shift;
    logic               tmr_mode;
    logic [CNT_W-1:0]   tmr_interval [NUM_CH];
    logic [NUM_CH-1:0]  tmr_enable;
    logic [PRESC_W-1:0] tmr_presc;
    logic [CNT_W-1:0]   tmr_count;
    logic [CNT_W-1:0]   tmr_compare [NUM_CH];

    t_out_item due_counts[$];
    logic      plan_typed = 1'b0;
    t_out_item plan_want  = '0;
    int        tx_idle_pct = 0;
    int        rx_idle_pct = 0;
    int        err_cnt = 0;
    int        n_req = 0;
    int        n_res = 0;
    int        n_fired = 0;
    int        n_wrap = 0;
    int        n_wr = 0;

    t_plan_row plan_tab [PLAN_ROWS] = '{
        '{ROW_REQ, REG_PRESCALE,  32'h0,         '{1'b0, 1'b0}, 1'b1, '{16'd0, 4'h0}},
        '{ROW_REQ, REG_PRESCALE,  32'h0,         '{1'b1, 1'b0}, 1'b1, '{16'd0, 4'h0}},
        '{ROW_REQ, REG_PRESCALE,  32'h0,         '{1'b1, 1'b0}, 1'b1, '{16'd1, 4'h0}},
        '{ROW_REQ, REG_PRESCALE,  32'h0,         '{1'b0, 1'b1}, 1'b1, '{16'd1, 4'h0}},
        '{ROW_REQ, REG_PRESCALE,  32'h0,         '{1'b1, 1'b1}, 1'b1, '{16'd1, 4'h0}},
        '{ROW_CFG, REG_PRESCALE,  32'hFFFF_FFF0, '{1'b0, 1'b0}, 1'b0, '{16'd0, 4'h0}},
        '{ROW_REQ, REG_PRESCALE,  32'h0,         '{1'b1, 1'b0}, 1'b1, '{16'd2, 4'h0}},
        '{ROW_CFG, REG_INTERVAL0, 32'h0000_0003, '{1'b0, 1'b0}, 1'b0, '{16'd0, 4'h0}},
        '{ROW_CFG, REG_INTERVAL1, 32'h0000_FFFF, '{1'b0, 1'b0}, 1'b0, '{16'd0, 4'h0}},
        '{ROW_CFG, REG_INTERVAL2, 32'h0000_0000, '{1'b0, 1'b0}, 1'b0, '{16'd0, 4'h0}},
        '{ROW_CFG, REG_INTERVAL3, 32'hABCD_0004, '{1'b0, 1'b0}, 1'b0, '{16'd0, 4'h0}},
        '{ROW_CFG, REG_ENABLE,    32'hFFFF_FFFF, '{1'b0, 1'b0}, 1'b0, '{16'd0, 4'h0}},
        '{ROW_REQ, REG_PRESCALE,  32'h0,         '{1'b1, 1'b0}, 1'b0, '{16'd0, 4'h0}},
        '{ROW_REQ, REG_PRESCALE,  32'h0,         '{1'b1, 1'b0}, 1'b0, '{16'd0, 4'h0}},
        '{ROW_CFG, REG_INTERVAL2, 32'h0000_0004, '{1'b0, 1'b0}, 1'b0, '{16'd0, 4'h0}},
        '{ROW_REQ, REG_PRESCALE,  32'h0,         '{1'b0, 1'b0}, 1'b1, '{16'd4, 4'h0}},
        '{ROW_REQ, REG_PRESCALE,  32'h0,         '{1'b0, 1'b1}, 1'b1, '{16'd4, 4'h0}},
        '{ROW_REQ, REG_PRESCALE,  32'h0,         '{1'b1, 1'b0}, 1'b0, '{16'd0, 4'h0}},
        '{ROW_CFG, REG_SPARE,     32'hFFFF_FFFF, '{1'b0, 1'b0}, 1'b0, '{16'd0, 4'h0}},
        '{ROW_CFG, REG_LAST,      32'h0000_0000, '{1'b0, 1'b0}, 1'b0, '{16'd0, 4'h0}},
        '{ROW_CFG, REG_MODE,      32'hFFFF_FFFF, '{1'b0, 1'b0}, 1'b0, '{16'd0, 4'h0}},
        '{ROW_REQ, REG_PRESCALE,  32'h0,         '{1'b1, 1'b0}, 1'b1, '{16'd5, 4'h0}},
        '{ROW_REQ, REG_PRESCALE,  32'h0,         '{1'b0, 1'b1}, 1'b0, '{16'd0, 4'h0}},
        '{ROW_REQ, REG_PRESCALE,  32'h0,         '{1'b1, 1'b1}, 1'b0, '{16'd0, 4'h0}},
        '{ROW_REQ, REG_PRESCALE,  32'h0,         '{1'b0, 1'b1}, 1'b0, '{16'd0, 4'h0}}
    };

    periodic_compare_timer_4ch DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic void write_timer_reg(logic [CFG_ADDR_W-1:0] idx,
                                            logic [CFG_DATA_W-1:0] data);
        int ch;
        if (idx == REG_PRESCALE) begin
            tmr_shift = data[SHIFT_W-1:0];
        end else if (idx == REG_MODE) begin
            tmr_mode = data[0];
        end else if (idx >= REG_INTERVAL0 && idx < REG_INTERVAL0 + CFG_ADDR_W'(NUM_CH)) begin
            ch = int'(idx - REG_INTERVAL0);
            tmr_interval[ch] = data[CNT_W-1:0];
            tmr_compare[ch]  = data[CNT_W-1:0];
        end else if (idx == REG_ENABLE) begin
            tmr_enable = data[NUM_CH-1:0];
        end
    endfunction

    function automatic t_out_item step_timer(t_in_item req);
        t_out_item res;
        logic      advance;
        int        eff_shift;
        advance = 1'b0;
        res.fired_mask = '0;
        if (!tmr_mode) begin
            if (req.base_tick) begin
                eff_shift = (int'(tmr_shift) > MAX_SHIFT) ? MAX_SHIFT : int'(tmr_shift);
                if (int'(tmr_presc) + 1 >= (1 << eff_shift)) begin
                    tmr_presc = '0;
                    advance   = 1'b1;
                end else begin
                    tmr_presc = tmr_presc + 1'b1;
                end
            end
        end else begin
            advance = req.count_pulse;
        end
        if (advance) begin
            tmr_count = tmr_count + 1'b1;
            if (tmr_count == '0)
                n_wrap++;
            for (int ch = 0; ch < NUM_CH; ch++) begin
                if (tmr_enable[ch] && tmr_compare[ch] == tmr_count) begin
                    tmr_compare[ch]    = tmr_compare[ch] + tmr_interval[ch];
                    res.fired_mask[ch] = 1'b1;
                end
            end
        end
        res.count_value = tmr_count;
        return res;
    endfunction

    function automatic t_in_item rand_req(int noise_pct);
        t_in_item r;
        r = t_in_item'(2'($urandom_range(0, 3)));
        if ($urandom_range(0, 99) >= noise_pct) begin
            if (tmr_mode)
                r.count_pulse = 1'b1;
            else
                r.base_tick = 1'b1;
        end
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] pick_interval();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return CNT_W'($urandom);
            default: return tmr_count + CNT_W'($urandom_range(1, 24));
        endcase
    endfunction

    // returns at the accepting rising edge
    task automatic send_req(t_in_item req, logic typed, t_out_item want);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        plan_typed = typed;
        plan_want  = want;
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // hold requests until every result is back
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (due_counts.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task automatic run_phase(int n_items);
        logic [SHIFT_W-1:0] shift;
        settle();
        case ($urandom_range(0, 9))
            0: shift = '1;
            1: shift = SHIFT_W'(MAX_SHIFT);
            default: shift = SHIFT_W'($urandom_range(0, 2));
        endcase
        write_reg(REG_PRESCALE, (CFG_DATA_W'($urandom) & ~CFG_DATA_W'(15)) | CFG_DATA_W'(shift));
        write_reg(REG_MODE, CFG_DATA_W'($urandom));
        for (int ch = 0; ch < NUM_CH; ch++)
            write_reg(REG_INTERVAL0 + CFG_ADDR_W'(ch),
                      {CNT_W'($urandom), pick_interval()});
        write_reg(REG_ENABLE, CFG_DATA_W'($urandom));
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_ADDR_W'($urandom_range(REG_SPARE, REG_LAST)), CFG_DATA_W'($urandom));
        repeat (n_items) send_req(rand_req(20), 1'b0, '0);
    endtask

    always @(negedge i_clk)
        i_out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);

    always @(posedge i_clk) begin : mon
        t_out_item want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                write_timer_reg(i_cfg_index, i_cfg_data);
                n_wr++;
            end
            if (i_in_valid && o_in_ready) begin
                want = step_timer(i_in_data);
                if (plan_typed)
                    want = plan_want;
                due_counts.push_back(want);
                n_req++;
            end
            if (o_out_valid && i_out_ready) begin
                n_res++;
                if (due_counts.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("%0t: result with none expected, actual count %h mask %h",
                                 $time, o_out_data.count_value, o_out_data.fired_mask);
                end else begin
                    want = due_counts.pop_front();
                    if (want.fired_mask != '0)
                        n_fired++;
                    if (o_out_data.count_value !== want.count_value) begin
                        err_cnt++;
                        if (err_cnt <= MAX_REPORTS)
                            $display("%0t: count_value expected %h actual %h",
                                     $time, want.count_value, o_out_data.count_value);
                    end
                    if (o_out_data.fired_mask !== want.fired_mask) begin
                        err_cnt++;
                        if (err_cnt <= MAX_REPORTS)
                            $display("%0t: fired_mask expected %h actual %h",
                                     $time, want.fired_mask, o_out_data.fired_mask);
                    end
                end
            end
        end
    end

    initial begin
        tmr_shift  = PRESCALE_RESET;
        tmr_mode   = 1'b0;
        tmr_enable = '0;
        tmr_presc  = '0;
        tmr_count  = '0;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            tmr_interval[ch] = '0;
            tmr_compare[ch]  = '0;
        end
        tx_idle_pct = 28;
        rx_idle_pct = 80;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan_tab[r]) begin
            if (plan_tab[r].kind == ROW_CFG) begin
                settle();
                write_reg(plan_tab[r].idx, plan_tab[r].data);
            end else begin
                send_req(plan_tab[r].req, plan_tab[r].typed, plan_tab[r].want);
            end
        end

        repeat (4) run_phase(20);
        tx_idle_pct = 80;
        rx_idle_pct = 28;
        repeat (4) run_phase(20);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (4) run_phase(20);

        // oversized prescale behaves as the largest divider
        settle();
        write_reg(REG_PRESCALE, CFG_DATA_W'('1));
        write_reg(REG_MODE, '0);
        write_reg(REG_INTERVAL0, CFG_DATA_W'(tmr_count + 1'b1));
        write_reg(REG_INTERVAL1, CFG_DATA_W'(tmr_count + 2'd2));
        write_reg(REG_INTERVAL2, CFG_DATA_W'(tmr_count + 2'd2));
        write_reg(REG_INTERVAL3, CFG_DATA_W'(tmr_count + 2'd3));
        write_reg(REG_ENABLE, CFG_DATA_W'('1));
        repeat (60) send_req(rand_req(5), 1'b0, '0);

        // counter mode with short, zero and maximum intervals
        settle();
        write_reg(REG_MODE, CFG_DATA_W'(1));
        write_reg(REG_INTERVAL0, CFG_DATA_W'(7));
        write_reg(REG_INTERVAL1, '0);
        write_reg(REG_INTERVAL2, CFG_DATA_W'(16'hFFFF));
        write_reg(REG_INTERVAL3, CFG_DATA_W'($urandom_range(1, 40)));
        write_reg(REG_ENABLE, CFG_DATA_W'('1));
        repeat (130) send_req(rand_req(6), 1'b0, '0);

        settle();
        $display("covered %0d requests and %0d results, %0d of them with channels firing",
                 n_req, n_res, n_fired);
        $display("%0d register writes, count wrapped %0d times, %0d mismatches",
                 n_wr, n_wrap, err_cnt);
        if (err_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("timeout with %0d results outstanding", due_counts.size());
        $display("status: fail");
        $finish;
    end

endmodule

@@ sim.f @@
design/pct4_pkg.sv
design/pct4_cfg.sv
design/pct4_core.sv
design/periodic_compare_timer_4ch.sv
dv/tb.sv
